### design/gnss_ascii_sentence_framer_assert.svh
// ----------------------------------------------------------------------------
// GNSS sentence framer assertion macros
// Concurrent checks on clock, disabled while reset is high. Empty bodies when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GNSS_ASCII_SENTENCE_FRAMER_ASSERT_SVH
`define GNSS_ASCII_SENTENCE_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define GASF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gnss framer: same-cycle check failed");

// Next-cycle implication.
`define GASF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gnss framer: next-cycle check failed");

`else

`define GASF_ASSERT_NOW(label, ante, cons)
`define GASF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### design/gasf_pkg.sv
// ----------------------------------------------------------------------------
// GNSS sentence framer package
// Character codes, phase and status codes, framing state and the per-byte
// update functions.
// ----------------------------------------------------------------------------
package gasf_pkg;

   localparam int MAX_SENTENCE_LENGTH = 255;
   localparam int MAX_FIELDS          = 63;
   localparam int FIELD_CAP           = (MAX_FIELDS < 63) ? MAX_FIELDS : 63;
   localparam int LEN_W               = $clog2(MAX_SENTENCE_LENGTH + 2);
   localparam int FIELD_W             = 6;
   localparam int STATUS_W            = 3;
   localparam int PHASE_W             = 3;

   // characters
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_DIG_0   = 8'h30;
   localparam logic [7:0] CH_DIG_9   = 8'h39;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_F    = 8'h46;
   localparam logic [7:0] CH_LO_A    = 8'h61;
   localparam logic [7:0] CH_LO_F    = 8'h66;
   localparam logic [7:0] HEX_TEN    = 8'd10;

   // framing phases
   localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
   localparam logic [PHASE_W-1:0] PH_NMEA = 3'd1;
   localparam logic [PHASE_W-1:0] PH_HEX  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_TAIL = 3'd3;
   localparam logic [PHASE_W-1:0] PH_VEND = 3'd4;

   // end status / error codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_HEX   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_STAR   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SEP_COUNT = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd5;

   localparam logic [1:0] SEMI_SAT = 2'd3;
   localparam logic [1:0] HEX_DONE = 2'd2;

   typedef struct packed {
      logic [PHASE_W-1:0]  phase;
      logic                cur_type;
      logic [7:0]          run_xor;
      logic [7:0]          hex_val;
      logic [1:0]          hex_seen;
      logic [1:0]          semi_cnt;
      logic [FIELD_W-1:0]  field_num;
      logic [FIELD_W-1:0]  fields_tot;
      logic [LEN_W-1:0]    sent_len;
      logic [STATUS_W-1:0] err_code;
      logic                pend_cr;
   } state_type;

   typedef struct packed {
      state_type  st;
      logic       emit;
      logic [7:0] ch;
   } absorb_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_of(logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b >= CH_DIG_0 && b <= CH_DIG_9) begin
         r = {1'b1, 4'(b - CH_DIG_0)};
      end else if (b >= CH_UP_A && b <= CH_UP_F) begin
         r = {1'b1, 4'(b - CH_UP_A + HEX_TEN)};
      end else if (b >= CH_LO_A && b <= CH_LO_F) begin
         r = {1'b1, 4'(b - CH_LO_A + HEX_TEN)};
      end
      return r;
   endfunction

   function automatic state_type start_state(logic vend);
      state_type s;
      s            = '0;
      s.cur_type   = vend;
      s.fields_tot = FIELD_W'(1);
      s.sent_len   = LEN_W'(1);
      s.phase      = vend ? PH_VEND : PH_NMEA;
      return s;
   endfunction

   function automatic state_type next_field(state_type s);
      state_type r;
      r = s;
      if (s.field_num < FIELD_W'(FIELD_CAP)) r.field_num = s.field_num + 1'b1;
      if (s.fields_tot < FIELD_W'(FIELD_CAP)) r.fields_tot = s.fields_tot + 1'b1;
      return r;
   endfunction

   // One byte inside a sentence; may_emit is low for a CR that was not
   // followed by LF.
   function automatic absorb_type absorb(state_type s, logic [7:0] b, logic may_emit,
                                         logic keep);
      absorb_type r;
      logic [4:0] hx;
      r.st   = s;
      r.emit = 1'b0;
      r.ch   = b;
      hx     = hex_of(b);
      if (s.sent_len <= LEN_W'(MAX_SENTENCE_LENGTH)) r.st.sent_len = s.sent_len + 1'b1;
      if (r.st.sent_len > LEN_W'(MAX_SENTENCE_LENGTH)) begin
         r.st.err_code = ST_TOO_LONG;
         r.st.phase    = PH_TAIL;
      end else begin
         case (s.phase)
            PH_NMEA: begin
               if (b == CH_STAR) begin
                  r.st.phase = PH_HEX;
                  r.emit     = keep;
               end else begin
                  r.st.run_xor = s.run_xor ^ b;
                  if (b == CH_COMMA) r.st = next_field(r.st);
                  else r.emit = may_emit;
               end
            end
            PH_HEX: begin
               if (!hx[4]) begin
                  r.st.err_code = ST_BAD_HEX;
                  r.st.phase    = PH_TAIL;
               end else begin
                  r.st.hex_val  = {s.hex_val[3:0], hx[3:0]};
                  r.st.hex_seen = s.hex_seen + 1'b1;
                  if (r.st.hex_seen >= HEX_DONE) r.st.phase = PH_TAIL;
                  r.emit = keep;
               end
            end
            PH_VEND: begin
               if (b == CH_STAR) begin
                  r.st.phase = PH_TAIL;
               end else if (b == CH_SEMI) begin
                  if (s.semi_cnt < SEMI_SAT) r.st.semi_cnt = s.semi_cnt + 1'b1;
                  r.st.field_num = '0;
                  if (s.fields_tot < FIELD_W'(FIELD_CAP)) begin
                     r.st.fields_tot = s.fields_tot + 1'b1;
                  end
               end else if (b == CH_COMMA) begin
                  r.st = next_field(r.st);
               end else begin
                  r.emit = may_emit;
               end
            end
            default: begin
            end
         endcase
      end
      return r;
   endfunction

endpackage

### design/gasf_req_if.sv
// ----------------------------------------------------------------------------
// GNSS sentence framer byte channel
// Valid/ready channel carrying one raw receiver byte per transaction.
// ----------------------------------------------------------------------------
interface gasf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

### design/gasf_rsp_if.sv
// ----------------------------------------------------------------------------
// GNSS sentence framer result channel
// Valid/ready channel carrying one character or end-of-sentence item.
// ----------------------------------------------------------------------------
interface gasf_rsp_if import gasf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                is_end;
   logic                sentence_type;
   logic [7:0]          char_value;
   logic                section;
   logic [FIELD_W-1:0]  field_index;
   logic [STATUS_W-1:0] status;
   logic [7:0]          received_checksum;
   logic [7:0]          computed_checksum;
   logic [FIELD_W-1:0]  field_count;

   modport source (output valid, output is_end, output sentence_type, output char_value,
                   output section, output field_index, output status,
                   output received_checksum, output computed_checksum, output field_count,
                   input ready);
   modport sink   (input valid, input is_end, input sentence_type, input char_value,
                   input section, input field_index, input status,
                   input received_checksum, input computed_checksum, input field_count,
                   output ready);
endinterface

### design/gasf_csr_if.sv
// ----------------------------------------------------------------------------
// GNSS sentence framer configuration channel
// Valid/ready write channel for the keep_delimiters register.
// ----------------------------------------------------------------------------
interface gasf_csr_if;
   logic valid;
   logic ready;
   logic keep_delimiters;

   modport source (output valid, output keep_delimiters, input ready);
   modport sink   (input valid, input keep_delimiters, output ready);
endinterface

### design/gnss_ascii_sentence_framer.sv
// ----------------------------------------------------------------------------
// GNSS ASCII sentence framer
// A result shows on rsp_chan in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the framing state updates in a single pass.
// The output register frees req_chan.ready whenever rsp_chan takes its item.
// Reset (synchronous, active high) returns to hunting and clears keep mode.
// ----------------------------------------------------------------------------
`include "gnss_ascii_sentence_framer_assert.svh"

module gnss_ascii_sentence_framer import gasf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   gasf_csr_if.sink      csr_chan,
   gasf_req_if.sink      req_chan,
   gasf_rsp_if.source    rsp_chan
);

   // Framing state and configuration
   state_type state_ff, state_in;
   logic      keep_ff;

   // Result register
   logic                rsp_valid_ff;
   logic                rsp_end_ff, rsp_end_in;
   logic                rsp_type_ff, rsp_type_in;
   logic [7:0]          rsp_char_ff, rsp_char_in;
   logic                rsp_section_ff, rsp_section_in;
   logic [FIELD_W-1:0]  rsp_field_ff, rsp_field_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_rx_ff, rsp_rx_in;
   logic [7:0]          rsp_cx_ff, rsp_cx_in;
   logic [FIELD_W-1:0]  rsp_count_ff, rsp_count_in;

   logic       req_acc;
   logic       emit_c;
   logic [7:0] byte_c;
   state_type  work_c;
   absorb_type cr_abs_c;
   absorb_type byte_abs_c;

   // Configuration writes are always taken.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         keep_ff <= csr_chan.keep_delimiters;
      end
   end

   // Accept a new byte while the result register is empty or being drained.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign byte_c         = req_chan.data_byte;

   // Both candidate absorb steps: a held CR that turns out to be a body byte,
   // then the current byte on top of whatever that CR left behind.
   always_comb begin
      work_c         = state_ff;
      work_c.pend_cr = 1'b0;
      cr_abs_c       = absorb(work_c, CH_CR, 1'b0, keep_ff);
      if (state_ff.pend_cr) work_c = cr_abs_c.st;
      byte_abs_c     = absorb(work_c, byte_c, 1'b1, keep_ff);
   end

   // Per-byte framing decision
   always_comb begin
      state_in       = state_ff;
      emit_c         = 1'b0;
      rsp_end_in     = 1'b0;
      rsp_type_in    = state_ff.cur_type;
      rsp_char_in    = byte_c;
      rsp_section_in = 1'b0;
      rsp_field_in   = state_ff.field_num;
      rsp_status_in  = ST_OK;
      rsp_rx_in      = '0;
      rsp_cx_in      = '0;
      rsp_count_in   = '0;

      if (state_ff.phase == PH_HUNT || state_ff.phase > PH_VEND) begin
         // Hunt: drop everything but a start flag.
         state_in.phase = PH_HUNT;
         if (byte_c == CH_DOLLAR) begin
            state_in     = start_state(1'b0);
            emit_c       = keep_ff;
            rsp_type_in  = 1'b0;
            rsp_field_in = '0;
         end else if (byte_c == CH_PERCENT) begin
            state_in = start_state(1'b1);
         end
      end else if (state_ff.pend_cr && byte_c == CH_LF) begin
         // CR LF closes the sentence: report type, status and checksums.
         state_in         = state_ff;
         state_in.pend_cr = 1'b0;
         state_in.phase   = PH_HUNT;
         emit_c           = 1'b1;
         rsp_end_in       = 1'b1;
         rsp_char_in      = '0;
         rsp_count_in     = state_ff.fields_tot;
         if (state_ff.cur_type) begin
            rsp_section_in = (state_ff.semi_cnt != 2'd0);
            if (state_ff.err_code == ST_TOO_LONG)  rsp_status_in = ST_TOO_LONG;
            else if (state_ff.phase == PH_VEND)    rsp_status_in = ST_NO_STAR;
            else if (state_ff.semi_cnt != 2'd1)    rsp_status_in = ST_SEP_COUNT;
            else                                   rsp_status_in = ST_OK;
         end else begin
            rsp_rx_in = state_ff.hex_val;
            rsp_cx_in = state_ff.run_xor;
            if (state_ff.err_code == ST_TOO_LONG)  rsp_status_in = ST_TOO_LONG;
            else if (state_ff.phase == PH_NMEA)    rsp_status_in = ST_NO_STAR;
            else if (state_ff.err_code == ST_BAD_HEX || state_ff.hex_seen < HEX_DONE) begin
               rsp_status_in = ST_BAD_HEX;
            end else if (state_ff.hex_val != state_ff.run_xor) begin
               rsp_status_in = ST_MISMATCH;
            end else begin
               rsp_status_in = ST_OK;
            end
         end
      end else if (byte_c == CH_CR) begin
         // Hold a CR until the next byte shows whether it ends the sentence.
         state_in         = work_c;
         state_in.pend_cr = 1'b1;
      end else begin
         state_in       = byte_abs_c.st;
         emit_c         = byte_abs_c.emit;
         rsp_char_in    = byte_abs_c.ch;
         rsp_field_in   = byte_abs_c.st.field_num;
         rsp_section_in = byte_abs_c.st.cur_type && (byte_abs_c.st.semi_cnt != 2'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_acc) begin
         state_ff <= state_in;
      end
   end

   // Result register: load on an emitting transaction, drop when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_acc) begin
         rsp_valid_ff <= emit_c;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && emit_c) begin
         rsp_end_ff     <= rsp_end_in;
         rsp_type_ff    <= rsp_type_in;
         rsp_char_ff    <= rsp_char_in;
         rsp_section_ff <= rsp_section_in;
         rsp_field_ff   <= rsp_field_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_rx_ff      <= rsp_rx_in;
         rsp_cx_ff      <= rsp_cx_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.is_end            = rsp_end_ff;
   assign rsp_chan.sentence_type     = rsp_type_ff;
   assign rsp_chan.char_value        = rsp_char_ff;
   assign rsp_chan.section           = rsp_section_ff;
   assign rsp_chan.field_index       = rsp_field_ff;
   assign rsp_chan.status            = rsp_status_ff;
   assign rsp_chan.received_checksum = rsp_rx_ff;
   assign rsp_chan.computed_checksum = rsp_cx_ff;
   assign rsp_chan.field_count       = rsp_count_ff;

   // An end item always sends the framer back to hunting.
   `GASF_ASSERT_NEXT(a_end_to_hunt, req_acc && emit_c && rsp_end_in, state_ff.phase == PH_HUNT)
   // The field number never runs ahead of the sentence's field total.
   `GASF_ASSERT_NOW(a_field_order, 1'b1, state_ff.field_num <= state_ff.fields_tot)
   // NMEA sentences have no body section.
   `GASF_ASSERT_NOW(a_nmea_header, rsp_valid_ff && !rsp_type_ff, !rsp_section_ff)
   // End items carry no character; character items carry no status.
   `GASF_ASSERT_NOW(a_end_no_char, rsp_valid_ff && rsp_end_ff, rsp_char_ff == 8'd0)
   `GASF_ASSERT_NOW(a_char_no_status, rsp_valid_ff && !rsp_end_ff, rsp_status_ff == ST_OK)

endmodule

### bench/gnss_ascii_sentence_framer_tb.sv
// ----------------------------------------------------------------------------
// GNSS ASCII sentence framer testbench
// Drives byte streams of NMEA and vendor sentences, well-formed and broken,
// through the framer under random source and sink idling. A behavioral
// framer predicts each character and end-of-sentence item, and every item
// taken from the result channel is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gnss_ascii_sentence_framer_tb import gasf_pkg::*; ();

   // one item on the result channel
   typedef struct packed {
      logic                is_end;
      logic                sentence_type;
      logic [7:0]          char_value;
      logic                section;
      logic [FIELD_W-1:0]  field_index;
      logic [STATUS_W-1:0] status;
      logic [7:0]          received_checksum;
      logic [7:0]          computed_checksum;
      logic [FIELD_W-1:0]  field_count;
   } frame_item_type;

   // one row of the directed stream; typed rows carry their expected item
   typedef struct packed {
      logic [7:0]     data;
      logic           typed;
      frame_item_type item;
   } dir_row_type;

   typedef enum int {
      NM_GOOD, NM_BAD_SUM, NM_BAD_HEX, NM_ONE_DIGIT, NM_NO_STAR, NM_TRAILER,
      NM_LONG, NM_WIDE
   } nmea_shape_type;

   typedef enum int {
      VD_GOOD, VD_NO_SEMI, VD_MANY_SEMI, VD_NO_STAR, VD_LONG
   } vendor_shape_type;

   localparam frame_item_type NO_ITEM   = '0;
   localparam int          N_DIRECT  = 26;
   localparam int          PHASE_ITEMS = 650;
   localparam int          LONG_HOLD = 300;
   localparam logic [7:0]  CH_UNDERSCORE = 8'h5F;

   // Directed stream: hunting noise at both byte extremes, a checksum
   // mismatch, a clean vendor sentence, a vendor sentence without ';',
   // an NMEA sentence without '*' carrying 8'hFF, and a non-hex digit.
   localparam dir_row_type DIRECTED_ROWS [N_DIRECT] = '{
      '{8'h00,      1'b0, NO_ITEM},
      '{8'hFF,      1'b0, NO_ITEM},
      '{CH_DOLLAR,  1'b0, NO_ITEM},
      '{CH_STAR,    1'b0, NO_ITEM},
      '{CH_DIG_0,   1'b0, NO_ITEM},
      '{8'h31,      1'b0, NO_ITEM},
      '{CH_CR,      1'b0, NO_ITEM},
      '{CH_LF,      1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 6'd0, ST_MISMATCH, 8'h01, 8'h00, 6'd1}},
      '{CH_PERCENT, 1'b0, NO_ITEM},
      '{CH_SEMI,    1'b0, NO_ITEM},
      '{CH_STAR,    1'b0, NO_ITEM},
      '{CH_CR,      1'b0, NO_ITEM},
      '{CH_LF,      1'b1, '{1'b1, 1'b1, 8'h00, 1'b1, 6'd0, ST_OK, 8'h00, 8'h00, 6'd2}},
      '{CH_PERCENT, 1'b0, NO_ITEM},
      '{CH_STAR,    1'b0, NO_ITEM},
      '{CH_CR,      1'b0, NO_ITEM},
      '{CH_LF,      1'b1, '{1'b1, 1'b1, 8'h00, 1'b0, 6'd0, ST_SEP_COUNT, 8'h00, 8'h00, 6'd1}},
      '{CH_DOLLAR,  1'b0, NO_ITEM},
      '{8'hFF,      1'b1, '{1'b0, 1'b0, 8'hFF, 1'b0, 6'd0, ST_OK, 8'h00, 8'h00, 6'd0}},
      '{CH_CR,      1'b0, NO_ITEM},
      '{CH_LF,      1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 6'd0, ST_NO_STAR, 8'h00, 8'hFF, 6'd1}},
      '{CH_DOLLAR,  1'b0, NO_ITEM},
      '{CH_STAR,    1'b0, NO_ITEM},
      '{8'h47,      1'b0, NO_ITEM},
      '{CH_CR,      1'b0, NO_ITEM},
      '{CH_LF,      1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 6'd0, ST_BAD_HEX, 8'h00, 8'h00, 6'd1}}
   };

   logic clock;
   logic reset;

   gasf_csr_if csr_chan ();
   gasf_req_if req_chan ();
   gasf_rsp_if rsp_chan ();

   gnss_ascii_sentence_framer DUT (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // items predicted but not yet seen on the result channel
   frame_item_type expected_frames[$];
   // bytes of the sentence being assembled for the stream
   logic [7:0]  line_bytes[$];

   int mismatch_count = 0;
   int bytes_sent;
   int src_gap_pct;
   int sink_gap_pct;
   int hold_asked;
   int hold_served;
   int hold_left;

   // behavioral framer state
   logic                keep_mode;
   logic [PHASE_W-1:0]  frm_phase;
   logic                frm_vendor;
   logic [7:0]          frm_xor;
   logic [7:0]          frm_hex;
   int                  frm_hex_cnt;
   logic [1:0]          frm_semis;
   logic [FIELD_W-1:0]  frm_field;
   logic [FIELD_W-1:0]  frm_total;
   int                  frm_len;
   logic [STATUS_W-1:0] frm_err;
   logic                frm_cr_wait;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Hard stop in case the block hangs on either channel.
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Behavioral framer
   // ------------------------------------------------------------------------

   function automatic int hex_nibble(logic [7:0] b);
      if (b >= CH_DIG_0 && b <= CH_DIG_9) return int'(b - CH_DIG_0);
      if (b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A) + 10;
      if (b >= CH_LO_A && b <= CH_LO_F) return int'(b - CH_LO_A) + 10;
      return -1;
   endfunction

   task automatic bump_field();
      if (frm_field < FIELD_CAP) frm_field = frm_field + 1'b1;
      if (frm_total < FIELD_CAP) frm_total = frm_total + 1'b1;
   endtask

   task automatic open_sentence(input logic vend);
      frm_vendor  = vend;
      frm_xor     = '0;
      frm_hex     = '0;
      frm_hex_cnt = 0;
      frm_semis   = '0;
      frm_field   = '0;
      frm_total   = FIELD_W'(1);
      frm_len     = 1;
      frm_err     = ST_OK;
      frm_cr_wait = 1'b0;
      frm_phase   = vend ? PH_VEND : PH_NMEA;
   endtask

   function automatic frame_item_type char_item(logic [7:0] c);
      frame_item_type it;
      it               = '0;
      it.sentence_type = frm_vendor;
      it.char_value    = c;
      it.section       = (frm_semis != 0);
      it.field_index   = frm_field;
      return it;
   endfunction

   // One byte inside a sentence; a CR that turned out not to end the line
   // is counted, and checksummed in an NMEA body, but never passed on.
   task automatic take_byte(input logic [7:0] b, input logic may_pass,
                            output logic has, output frame_item_type it);
      int nib;
      has = 1'b0;
      it  = '0;
      if (frm_len <= MAX_SENTENCE_LENGTH) frm_len++;
      if (frm_len > MAX_SENTENCE_LENGTH) begin
         frm_err   = ST_TOO_LONG;
         frm_phase = PH_TAIL;
         return;
      end
      case (frm_phase)
         PH_NMEA: begin
            if (b == CH_STAR) begin
               frm_phase = PH_HEX;
               has       = keep_mode;
            end else begin
               frm_xor = frm_xor ^ b;
               if (b == CH_COMMA) bump_field();
               else has = may_pass;
            end
         end
         PH_HEX: begin
            nib = hex_nibble(b);
            if (nib < 0) begin
               frm_err   = ST_BAD_HEX;
               frm_phase = PH_TAIL;
            end else begin
               frm_hex = {frm_hex[3:0], 4'(nib)};
               frm_hex_cnt++;
               if (frm_hex_cnt >= 2) frm_phase = PH_TAIL;
               has = keep_mode;
            end
         end
         PH_VEND: begin
            if (b == CH_STAR) begin
               frm_phase = PH_TAIL;
            end else if (b == CH_SEMI) begin
               if (frm_semis < SEMI_SAT) frm_semis = frm_semis + 1'b1;
               frm_field = '0;
               if (frm_total < FIELD_CAP) frm_total = frm_total + 1'b1;
            end else if (b == CH_COMMA) begin
               bump_field();
            end else begin
               has = may_pass;
            end
         end
         default: begin
         end
      endcase
      if (has) it = char_item(b);
   endtask

   // CR LF seen: build the end item and go back to hunting.
   function automatic frame_item_type close_sentence();
      frame_item_type it;
      it               = '0;
      it.is_end        = 1'b1;
      it.sentence_type = frm_vendor;
      it.section       = (frm_semis != 0);
      it.field_index   = frm_field;
      it.field_count   = frm_total;
      if (frm_vendor) begin
         if (frm_err == ST_TOO_LONG) it.status = ST_TOO_LONG;
         else if (frm_phase == PH_VEND) it.status = ST_NO_STAR;
         else if (frm_semis != 1) it.status = ST_SEP_COUNT;
         else it.status = ST_OK;
      end else begin
         it.received_checksum = frm_hex;
         it.computed_checksum = frm_xor;
         if (frm_err == ST_TOO_LONG) it.status = ST_TOO_LONG;
         else if (frm_phase == PH_NMEA) it.status = ST_NO_STAR;
         else if (frm_err == ST_BAD_HEX || frm_hex_cnt < 2) it.status = ST_BAD_HEX;
         else if (frm_hex != frm_xor) it.status = ST_MISMATCH;
         else it.status = ST_OK;
      end
      frm_phase   = PH_HUNT;
      frm_cr_wait = 1'b0;
      return it;
   endfunction

   // Advance the behavioral framer by one stream byte.
   task automatic frame_byte(input logic [7:0] b, output logic has,
                             output frame_item_type it);
      logic           lone_has;
      frame_item_type lone_it;
      has = 1'b0;
      it  = '0;
      if (frm_phase == PH_HUNT || frm_phase > PH_VEND) begin
         frm_phase = PH_HUNT;
         if (b == CH_DOLLAR) begin
            open_sentence(1'b0);
            has = keep_mode;
            if (has) it = char_item(b);
         end else if (b == CH_PERCENT) begin
            open_sentence(1'b1);
         end
         return;
      end
      if (frm_cr_wait) begin
         frm_cr_wait = 1'b0;
         if (b == CH_LF) begin
            has = 1'b1;
            it  = close_sentence();
            return;
         end
         take_byte(CH_CR, 1'b0, lone_has, lone_it);
      end
      if (b == CH_CR) begin
         frm_cr_wait = 1'b1;
         return;
      end
      take_byte(b, 1'b1, has, it);
   endtask

   // ------------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------------

   // Offer one byte, idling first at the source's rate, and hold it until
   // the block takes it. Typed rows replace the predicted item.
   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input frame_item_type typed_it);
      logic           has;
      frame_item_type it;
      while ($urandom_range(0, 99) < src_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
      frame_byte(b, has, it);
      if (has) expected_frames.push_back(typed ? typed_it : it);
   endtask

   task automatic send_line();
      while (line_bytes.size() != 0) send_byte(line_bytes.pop_front(), 1'b0, NO_ITEM);
   endtask

   // Drop valid and wait for every predicted item, then let the pipeline
   // settle since the last bytes may have produced nothing.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_keep(input logic value);
      csr_chan.valid           <= 1'b1;
      csr_chan.keep_delimiters <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      keep_mode = value;
   endtask

   // ------------------------------------------------------------------------
   // Sentence generation
   // ------------------------------------------------------------------------

   function automatic logic [7:0] hex_char(logic [3:0] nib, logic lower);
      if (nib < 10) return CH_DIG_0 + 8'(nib);
      return (lower ? CH_LO_A : CH_UP_A) + 8'(nib) - HEX_TEN;
   endfunction

   // Append body bytes. Mostly printable text and commas, some raw bytes
   // and the odd CR that is not followed by LF.
   task automatic add_body(input logic vend, input int count, input int comma_pct,
                           inout logic [7:0] sum);
      logic [7:0] c;
      int         r;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < comma_pct) begin
            c = CH_COMMA;
         end else if (r < comma_pct + 4) begin
            line_bytes.push_back(CH_CR);
            sum = sum ^ CH_CR;
            c   = 8'($urandom_range(8'h41, 8'h5A));
         end else if (r < comma_pct + 12) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_STAR || c == CH_CR || (vend && c == CH_SEMI)) c = CH_DIG_0;
         end else begin
            c = 8'($urandom_range(8'h20, 8'h7E));
            if (c == CH_STAR || (vend && c == CH_SEMI)) c = CH_UNDERSCORE;
         end
         line_bytes.push_back(c);
         sum = sum ^ c;
      end
   endtask

   task automatic build_nmea(input nmea_shape_type shape);
      logic [7:0] sum;
      logic [7:0] sent_sum;
      logic       lower;
      int         len;
      int         commas;
      sum    = '0;
      lower  = 1'($urandom_range(0, 1));
      len    = $urandom_range(0, 24);
      commas = 15;
      if (shape == NM_LONG) len = $urandom_range(249, 258);
      if (shape == NM_WIDE) begin
         len    = $urandom_range(70, 110);
         commas = 70;
      end
      line_bytes.push_back(CH_DOLLAR);
      add_body(1'b0, len, commas, sum);
      sent_sum = sum;
      if (shape == NM_BAD_SUM) sent_sum = sum ^ 8'($urandom_range(1, 255));
      if (shape != NM_NO_STAR) begin
         line_bytes.push_back(CH_STAR);
         case (shape)
            NM_ONE_DIGIT: line_bytes.push_back(hex_char(sent_sum[7:4], lower));
            NM_BAD_HEX: begin
               if ($urandom_range(0, 1)) line_bytes.push_back(hex_char(sent_sum[7:4], lower));
               line_bytes.push_back(8'($urandom_range(8'h67, 8'h7A)));
            end
            default: begin
               line_bytes.push_back(hex_char(sent_sum[7:4], lower));
               line_bytes.push_back(hex_char(sent_sum[3:0], !lower));
               if (shape == NM_TRAILER) add_body(1'b0, $urandom_range(1, 5), 20, sum);
            end
         endcase
      end
      line_bytes.push_back(CH_CR);
      line_bytes.push_back(CH_LF);
   endtask

   task automatic build_vendor(input vendor_shape_type shape);
      logic [7:0] sum;
      int         semis;
      int         head_len;
      sum      = '0;
      semis    = 1;
      head_len = $urandom_range(0, 14);
      if (shape == VD_NO_SEMI) semis = 0;
      if (shape == VD_MANY_SEMI) semis = $urandom_range(2, 5);
      if (shape == VD_LONG) head_len = $urandom_range(240, 256);
      line_bytes.push_back(CH_PERCENT);
      add_body(1'b1, head_len, 20, sum);
      repeat (semis) begin
         line_bytes.push_back(CH_SEMI);
         add_body(1'b1, $urandom_range(0, 12), 20, sum);
      end
      if (shape != VD_NO_STAR) begin
         line_bytes.push_back(CH_STAR);
         repeat (8) line_bytes.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
      end
      line_bytes.push_back(CH_CR);
      line_bytes.push_back(CH_LF);
   endtask

   // Mostly well-formed sentences with random content, the rest broken,
   // with a little noise between them.
   task automatic build_random_line();
      int r;
      int s;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         repeat ($urandom_range(1, 3)) line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      s = $urandom_range(0, 99);
      if ($urandom_range(0, 1)) begin
         if (s < 55) build_nmea(NM_GOOD);
         else if (s < 65) build_nmea(NM_BAD_SUM);
         else if (s < 73) build_nmea(NM_BAD_HEX);
         else if (s < 79) build_nmea(NM_ONE_DIGIT);
         else if (s < 85) build_nmea(NM_NO_STAR);
         else if (s < 93) build_nmea(NM_TRAILER);
         else if (s < 97) build_nmea(NM_WIDE);
         else build_nmea(NM_LONG);
      end else begin
         if (s < 60) build_vendor(VD_GOOD);
         else if (s < 72) build_vendor(VD_NO_SEMI);
         else if (s < 85) build_vendor(VD_MANY_SEMI);
         else if (s < 97) build_vendor(VD_NO_STAR);
         else build_vendor(VD_LONG);
      end
   endtask

   // ------------------------------------------------------------------------
   // Result channel: random backpressure, long hold-offs on request, checks
   // ------------------------------------------------------------------------

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_frame(input frame_item_type got);
      frame_item_type want;
      if (expected_frames.size() == 0) begin
         $display("%0t: unexpected item, expected none, got %h", $time, got);
         mismatch_count++;
         return;
      end
      want = expected_frames.pop_front();
      report_field("is_end", int'(want.is_end), int'(got.is_end));
      report_field("sentence_type", int'(want.sentence_type), int'(got.sentence_type));
      report_field("char_value", int'(want.char_value), int'(got.char_value));
      report_field("section", int'(want.section), int'(got.section));
      report_field("field_index", int'(want.field_index), int'(got.field_index));
      report_field("status", int'(want.status), int'(got.status));
      report_field("received_checksum", int'(want.received_checksum),
                   int'(got.received_checksum));
      report_field("computed_checksum", int'(want.computed_checksum),
                   int'(got.computed_checksum));
      report_field("field_count", int'(want.field_count), int'(got.field_count));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
         hold_served    <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_frame('{rsp_chan.is_end, rsp_chan.sentence_type, rsp_chan.char_value,
                          rsp_chan.section, rsp_chan.field_index, rsp_chan.status,
                          rsp_chan.received_checksum, rsp_chan.computed_checksum,
                          rsp_chan.field_count});
         end
         // A long hold-off lets the block fill up and stall its input.
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left      <= hold_left - 1;
         end else if (hold_asked != hold_served) begin
            rsp_chan.ready <= 1'b0;
            hold_left      <= LONG_HOLD;
            hold_served    <= hold_served + 1;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= sink_gap_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------

   initial begin
      int phase_no;
      bytes_sent     = 0;
      hold_asked     = 0;
      src_gap_pct    = 30;
      sink_gap_pct   = 58;
      keep_mode      = 1'b0;
      frm_phase      = PH_HUNT;
      frm_vendor     = 1'b0;
      frm_xor        = '0;
      frm_hex        = '0;
      frm_hex_cnt    = 0;
      frm_semis      = '0;
      frm_field      = '0;
      frm_total      = '0;
      frm_len        = 0;
      frm_err        = ST_OK;
      frm_cr_wait    = 1'b0;

      reset                    <= 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.data_byte       <= '0;
      csr_chan.valid           <= 1'b0;
      csr_chan.keep_delimiters <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed stream with the delimiters stripped.
      write_keep(1'b0);
      for (int i = 0; i < N_DIRECT; i++) begin
         send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].item);
      end
      wait_drained();

      // Three random phases: sink-heavy idling, source-heavy idling, none.
      for (phase_no = 0; phase_no < 3; phase_no++) begin
         src_gap_pct  = (phase_no == 0) ? 30 : (phase_no == 1) ? 58 : 0;
         sink_gap_pct = (phase_no == 0) ? 58 : (phase_no == 1) ? 30 : 0;
         write_keep(phase_no != 1);

         // Open each phase on the length limit and the field counter cap.
         build_nmea(NM_LONG);
         build_vendor(VD_LONG);
         build_nmea(NM_WIDE);
         send_line();

         if (phase_no == 0) begin
            // Hold the sink off while two sentences keep arriving.
            hold_asked++;
            build_nmea(NM_GOOD);
            build_nmea(NM_GOOD);
            send_line();
         end

         while (bytes_sent < PHASE_ITEMS * (phase_no + 1)) begin
            build_random_line();
            send_line();
            // In the second phase, pause the source mid-phase until everything has drained.
            if (phase_no == 1 && bytes_sent > PHASE_ITEMS + PHASE_ITEMS / 2 &&
                bytes_sent < PHASE_ITEMS + PHASE_ITEMS / 2 + 40) begin
               wait_drained();
            end
         end
         wait_drained();
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/gasf_pkg.sv
design/gasf_req_if.sv
design/gasf_rsp_if.sv
design/gasf_csr_if.sv
design/gnss_ascii_sentence_framer.sv
bench/gnss_ascii_sentence_framer_tb.sv
